### design/spimc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimc_pkg: shared types and constants of the serial master engine
// Transaction payloads, configuration bundle, register indexes and the CRC-8
// column table for polynomial 0x1D.
// ----------------------------------------------------------------------------
package spimc_pkg;

	localparam int unsigned FRAME_BITS = 32;
	localparam int unsigned MSG_BITS   = 24;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned TICK_W     = 8;
	localparam int unsigned ADDR_W     = 3;

	localparam logic [CNT_W-1:0]  FRAME_CNT = CNT_W'(FRAME_BITS);
	localparam logic [TICK_W-1:0] TICK_MAX  = '1;
	localparam logic [TICK_W-1:0] HIGH_RST  = 8'd5;
	localparam logic [TICK_W-1:0] LOW_RST   = 8'd1;

	typedef enum logic [0:0] {
		REG_CLOCK_HIGH = 1'b0,
		REG_CLOCK_LOW  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic       data_in_level;
	} in_t;

	typedef struct packed {
		logic        clock_level;
		logic        data_out_level;
		logic        busy_res;
		logic        done_res;
		logic [31:0] received_word;
	} out_t;

	typedef struct packed {
		logic [TICK_W-1:0] clock_high_ticks;
		logic [TICK_W-1:0] clock_low_ticks;
	} cfg_t;

	typedef struct packed {
		logic active;
	} status_t;

	// CRC contribution of each message bit, index 0 is the least significant.
	localparam logic [7:0] CRC_COL [MSG_BITS] = '{
		8'h1D, 8'h3A, 8'h74, 8'hE8, 8'hCD, 8'h87, 8'h13, 8'h26,
		8'h4C, 8'h98, 8'h2D, 8'h5A, 8'hB4, 8'h75, 8'hEA, 8'hC9,
		8'h8F, 8'h03, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'hC0
	};

endpackage

### design/spimc_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimc_crc8: frame builder
// Forms the 32-bit frame from three command bytes and their CRC-8.
// ----------------------------------------------------------------------------
module spimc_crc8 (
	input  logic [7:0]  first_byte,
	input  logic [7:0]  second_byte,
	input  logic [7:0]  third_byte,
	output logic [31:0] frame
);

	logic [spimc_pkg::MSG_BITS-1:0] msg;
	logic [7:0]                     crc;

	assign msg = {first_byte, second_byte, third_byte};

	always_comb begin
		crc = '0;
		for (int i = 0; i < int'(spimc_pkg::MSG_BITS); i++) begin
			if (msg[i]) begin
				crc = crc ^ spimc_pkg::CRC_COL[i];
			end
		end
	end

	assign frame = {msg, crc};

endmodule

### design/spimc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimc_regs: configuration registers
// APB-style access to the clock high and clock low tick counts.
// ----------------------------------------------------------------------------
module spimc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spimc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output spimc_pkg::cfg_t              cfg
);

	logic [7:0]          high_q;
	logic [7:0]          low_q;
	logic                wr_en;
	spimc_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = spimc_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= spimc_pkg::HIGH_RST;
			low_q  <= spimc_pkg::LOW_RST;
		end else if (wr_en) begin
			case (idx)
				spimc_pkg::REG_CLOCK_HIGH: high_q <= pwdata[7:0];
				spimc_pkg::REG_CLOCK_LOW:  low_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			spimc_pkg::REG_CLOCK_HIGH: prdata = {24'd0, high_q};
			spimc_pkg::REG_CLOCK_LOW:  prdata = {24'd0, low_q};
			default:                   prdata = '0;
		endcase
	end

	assign cfg.clock_high_ticks = high_q;
	assign cfg.clock_low_ticks  = low_q;

endmodule

### design/spimc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimc_engine: bit timing and shift engine
// Holds the transfer state and computes one tick's result and next state.
// ----------------------------------------------------------------------------
module spimc_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  spimc_pkg::in_t     in_data,
	input  spimc_pkg::cfg_t    cfg,
	output spimc_pkg::out_t    res,
	output spimc_pkg::status_t status
);

	logic [31:0]                  send_q, recv_q, frame;
	logic [spimc_pkg::CNT_W-1:0]  bits_q;
	logic [spimc_pkg::TICK_W-1:0] ticks_q;
	logic                         phase_q, active_q;

	logic [31:0]                  send_d, recv_d, send_c, recv_c;
	logic [spimc_pkg::CNT_W-1:0]  bits_d, bits_c, bits_m;
	logic [spimc_pkg::TICK_W-1:0] ticks_d, ticks_c, ticks_inc;
	logic                         phase_d, phase_c, active_d, starting, act;

	spimc_crc8 u_crc (
		.first_byte  (in_data.first_byte),
		.second_byte (in_data.second_byte),
		.third_byte  (in_data.third_byte),
		.frame       (frame)
	);

	assign starting = ~active_q & in_data.start_req;
	assign act      = active_q | starting;

	always_comb begin
		send_c    = starting ? frame : send_q;
		recv_c    = starting ? '0 : recv_q;
		bits_c    = starting ? spimc_pkg::FRAME_CNT : bits_q;
		phase_c   = starting | phase_q;
		ticks_c   = starting ? '0 : ticks_q;
		ticks_inc = (ticks_c != spimc_pkg::TICK_MAX) ? ticks_c + 1'b1 : ticks_c;
		bits_m    = bits_c - 1'b1;

		send_d    = send_q;
		recv_d    = recv_q;
		bits_d    = bits_q;
		phase_d   = phase_q;
		ticks_d   = ticks_q;
		active_d  = active_q;
		res       = '0;
		res.received_word = recv_q;

		if (act) begin
			res.busy_res       = 1'b1;
			res.clock_level    = phase_c;
			res.data_out_level = send_c[31];
			send_d   = send_c;
			recv_d   = recv_c;
			bits_d   = bits_c;
			phase_d  = phase_c;
			ticks_d  = ticks_inc;
			active_d = 1'b1;
			if (phase_c) begin
				if (ticks_inc >= cfg.clock_high_ticks) begin
					phase_d = 1'b0;
					ticks_d = '0;
				end
			end else if (ticks_inc >= cfg.clock_low_ticks) begin
				recv_d  = {recv_c[30:0], in_data.data_in_level};
				send_d  = {send_c[30:0], 1'b0};
				ticks_d = '0;
				phase_d = 1'b1;
				bits_d  = bits_m;
				if (bits_m == '0) begin
					active_d     = 1'b0;
					phase_d      = 1'b0;
					res.done_res = 1'b1;
				end
			end
			res.received_word = recv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_q   <= '0;
			recv_q   <= '0;
			bits_q   <= '0;
			phase_q  <= 1'b0;
			ticks_q  <= '0;
			active_q <= 1'b0;
		end else if (tick) begin
			send_q   <= send_d;
			recv_q   <= recv_d;
			bits_q   <= bits_d;
			phase_q  <= phase_d;
			ticks_q  <= ticks_d;
			active_q <= active_d;
		end
	end

	assign status.active = active_q;

endmodule

### design/spi_master_crc8_transaction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_crc8_transaction: serial master engine with CRC-8 framing
// Each input transaction is one tick of the serial bit timing. A start tick
// while idle latches three command bytes, appends their CRC-8 (poly 0x1D)
// and shifts the 32-bit frame out MSB first while sampling data-in.
//
// Input channel in_valid/in_ready/in_data carries one tick per transaction;
// output channel out_valid/out_ready/out_data returns one result per tick.
// The result is registered and offered in the cycle after input acceptance.
// Throughput is one transaction per cycle: the tick is computed in a single
// pass from the state registers into the output register, and a new tick is
// accepted whenever the output register is empty or being drained.
// When the receiver stalls, in_ready falls and the engine state holds.
// A transfer lasts 32 * (high + low) ticks with each count taken as at least 1.
// Reset clears the engine to idle, empties the output register and loads the
// tick counts with 5 (high) and 1 (low). The APB port always has pready high.
// ----------------------------------------------------------------------------
module spi_master_crc8_transaction (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  spimc_pkg::in_t               in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output spimc_pkg::out_t              out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spimc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	spimc_pkg::cfg_t    cfg;
	spimc_pkg::out_t    res;
	spimc_pkg::status_t status;
	spimc_pkg::out_t    out_q;
	logic               out_valid_q;
	logic               accept;

	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;

	spimc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spimc_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (accept),
		.in_data (in_data),
		.cfg     (cfg),
		.res     (res),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted tick produced no result");

	a_done_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |-> (out_q.busy_res && !status.active))
		else $error("done reported outside a transaction end");

	a_idle_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.busy_res) |-> (!out_q.clock_level && !out_q.data_out_level))
		else $error("serial pins driven while idle");

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status.active) |=> out_q.busy_res)
		else $error("active engine reported not busy");

endmodule

### test/spi_master_crc8_transaction_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_crc8_transaction_test: self-checking bench for the serial master
// One input transaction is one tick of the bit timing. The bench keeps its own
// model of the engine and CRC-8 framing, predicts the pin levels and received
// word of every tick, and checks each output transaction in order. It covers
// idle ticks, starts while busy, zero and extreme tick counts, tick-count
// changes during a transfer, and random transfers under bursty input and a
// stalling receiver with one long hold-off.
// ----------------------------------------------------------------------------
module spi_master_crc8_transaction_test;

	localparam logic [7:0] CRC8_POLY    = 8'h1D;
	localparam int         RANDOM_TICKS = 40;
	localparam int         HOLD_AT      = 500;
	localparam int         HOLD_CYCLES  = 80;
	localparam int         IDLE_LIMIT   = 4000;
	localparam int         END_TAIL     = 10;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	spimc_pkg::in_t  in_data  = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	spimc_pkg::out_t out_data;
	logic            psel     = 1'b0;
	logic            penable  = 1'b0;
	logic            pwrite   = 1'b0;
	logic [2:0]      paddr    = '0;
	logic [31:0]     pwdata   = '0;
	logic [31:0]     prdata;
	logic            pready;

	spi_master_crc8_transaction dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Engine state as the bench expects it.
	logic [spimc_pkg::TICK_W-1:0] cfg_high = spimc_pkg::HIGH_RST;
	logic [spimc_pkg::TICK_W-1:0] cfg_low  = spimc_pkg::LOW_RST;
	logic [31:0]                  eng_send = '0;
	logic [31:0]                  eng_recv = '0;
	logic [spimc_pkg::CNT_W-1:0]  eng_bits_left = '0;
	logic                         eng_clock_high = 1'b0;
	logic [spimc_pkg::TICK_W-1:0] eng_phase_ticks = '0;
	logic                         eng_active = 1'b0;

	spimc_pkg::in_t  tick_queue[$];
	spimc_pkg::out_t expected_pins[$];

	int mismatch_count    = 0;
	int ticks_accepted    = 0;
	int results_checked   = 0;
	int transfers_done    = 0;
	int settings_written  = 0;
	int idle_cycles       = 0;
	int random_ticks      = 0;

	function automatic logic [7:0] crc8_of(input logic [23:0] msg);
		logic [7:0] crc;
		crc = 8'h00;
		for (int i = 23; i >= 0; i--) begin
			if (crc[7] ^ msg[i]) begin
				crc = {crc[6:0], 1'b0} ^ CRC8_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
		end
		return crc;
	endfunction

	function automatic int frame_ticks();
		int h;
		int l;
		h = (cfg_high == 0) ? 1 : int'(cfg_high);
		l = (cfg_low == 0) ? 1 : int'(cfg_low);
		return 32 * (h + l);
	endfunction

	task automatic step_serial_engine(input spimc_pkg::in_t t);
		spimc_pkg::out_t r;
		r = '0;
		if (!eng_active && t.start_req) begin
			eng_send = {t.first_byte, t.second_byte, t.third_byte,
			            crc8_of({t.first_byte, t.second_byte, t.third_byte})};
			eng_recv = '0;
			eng_bits_left = spimc_pkg::FRAME_CNT;
			eng_clock_high = 1'b1;
			eng_phase_ticks = '0;
			eng_active = 1'b1;
		end
		if (eng_active) begin
			r.busy_res = 1'b1;
			r.clock_level = eng_clock_high;
			r.data_out_level = eng_send[31];
			if (eng_phase_ticks != spimc_pkg::TICK_MAX) begin
				eng_phase_ticks = eng_phase_ticks + 1'b1;
			end
			if (eng_clock_high) begin
				if (eng_phase_ticks >= cfg_high) begin
					eng_clock_high = 1'b0;
					eng_phase_ticks = '0;
				end
			end else if (eng_phase_ticks >= cfg_low) begin
				eng_recv = {eng_recv[30:0], t.data_in_level};
				eng_send = eng_send << 1;
				eng_phase_ticks = '0;
				eng_clock_high = 1'b1;
				eng_bits_left = eng_bits_left - 1'b1;
				if (eng_bits_left == 0) begin
					eng_active = 1'b0;
					eng_clock_high = 1'b0;
					r.done_res = 1'b1;
				end
			end
		end
		r.received_word = eng_recv;
		expected_pins.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
	                               input logic [31:0] got);
		$display("MISMATCH result %0d: %s expected %h got %h",
		         results_checked, what, want, got);
		mismatch_count++;
	endtask

	// Driver: bursts of random length with random gaps between them.
	spimc_pkg::in_t next_tick;
	logic           next_valid;
	int             burst_left = 0;
	int             gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			next_valid = in_valid;
			next_tick = in_data;
			if (in_valid && in_ready) begin
				step_serial_engine(in_data);
				ticks_accepted++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (tick_queue.size() > 0) begin
					next_tick = tick_queue.pop_front();
					next_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= next_valid;
			in_data <= next_tick;
		end
	end

	// Monitor: checks every output transaction and stalls on its own pattern.
	spimc_pkg::out_t want;
	logic            next_ready;
	logic [7:0]      stall_cycle = '0;
	int              hold_left   = 0;
	logic            long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_pins.size() == 0) begin
					report_mismatch("result with nothing expected", '0, out_data.received_word);
				end else begin
					want = expected_pins.pop_front();
					if (out_data.clock_level !== want.clock_level)
						report_mismatch("clock_level", 32'(want.clock_level),
						                32'(out_data.clock_level));
					if (out_data.data_out_level !== want.data_out_level)
						report_mismatch("data_out_level", 32'(want.data_out_level),
						                32'(out_data.data_out_level));
					if (out_data.busy_res !== want.busy_res)
						report_mismatch("busy_res", 32'(want.busy_res),
						                32'(out_data.busy_res));
					if (out_data.done_res !== want.done_res)
						report_mismatch("done_res", 32'(want.done_res),
						                32'(out_data.done_res));
					if (out_data.received_word !== want.received_word)
						report_mismatch("received_word", want.received_word,
						                out_data.received_word);
					if (want.done_res)
						transfers_done++;
				end
				results_checked++;
			end
			stall_cycle = stall_cycle + 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (!long_hold_done && results_checked >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				long_hold_done = 1'b1;
				next_ready = 1'b0;
			end else begin
				case (stall_cycle[7:6])
					2'd0: next_ready = 1'b1;
					2'd1: next_ready = (stall_cycle[1:0] != 2'd0);
					2'd2: next_ready = 1'($urandom_range(0, 1));
					default: next_ready = ($urandom_range(0, 3) != 0);
				endcase
			end
			out_ready <= next_ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
					$display("spi_master_crc8_transaction_test NOT OK");
					$finish;
				end
			end
		end
	end

	task automatic queue_tick(input logic start, input logic [7:0] a, input logic [7:0] b,
	                          input logic [7:0] c, input logic din);
		spimc_pkg::in_t t;
		t.start_req = start;
		t.first_byte = a;
		t.second_byte = b;
		t.third_byte = c;
		t.data_in_level = din;
		tick_queue.push_back(t);
	endtask

	// A plain tick carries random bytes and now and then a start that the
	// engine should ignore while busy.
	task automatic queue_plain(input int count);
		repeat (count) begin
			queue_tick($urandom_range(0, 11) == 0, 8'($urandom_range(0, 255)),
			           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			           1'($urandom_range(0, 1)));
		end
	endtask

	task automatic queue_transfer(input logic [7:0] a, input logic [7:0] b,
	                              input logic [7:0] c, input int len);
		queue_tick(1'b1, a, b, c, 1'($urandom_range(0, 1)));
		queue_plain(len - 1);
	endtask

	task automatic settle_outputs();
		@(negedge clk);
		while (tick_queue.size() != 0 || in_valid || expected_pins.size() != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_tick_count(input spimc_pkg::reg_idx_t which,
	                                input logic [7:0] value);
		logic [31:0] word;
		word = $urandom();
		word[7:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (which)
			spimc_pkg::REG_CLOCK_HIGH: cfg_high = value;
			spimc_pkg::REG_CLOCK_LOW:  cfg_low = value;
			default: ;
		endcase
		settings_written++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'h0, value})
			report_mismatch("register readback", {24'h0, value}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_tick_count();
		return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
	endfunction

	int len;
	int gaps;
	int transfers_left = 0;

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset tick counts: idle ticks, an all-ones frame and a start while busy.
		queue_tick(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_tick(1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_tick(1'b0, 8'h5A, 8'hA5, 8'h3C, 1'b1);
		queue_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_tick(1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_plain(frame_ticks() - 2);
		queue_tick(1'b0, 8'h81, 8'h42, 8'h24, 1'b0);
		settle_outputs();

		// Shortest bit time: all-zero frame, back-to-back frames, start on done.
		write_tick_count(spimc_pkg::REG_CLOCK_HIGH, 8'd1);
		write_tick_count(spimc_pkg::REG_CLOCK_LOW, 8'd1);
		queue_transfer(8'h00, 8'h00, 8'h00, frame_ticks());
		queue_transfer(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
		               8'($urandom_range(0, 255)), frame_ticks() - 1);
		queue_tick(1'b1, 8'h12, 8'h34, 8'h56, 1'b1);
		queue_tick(1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
		settle_outputs();

		// Zero counts behave as one.
		write_tick_count(spimc_pkg::REG_CLOCK_HIGH, 8'd0);
		write_tick_count(spimc_pkg::REG_CLOCK_LOW, 8'd0);
		queue_transfer(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
		               8'($urandom_range(0, 255)), frame_ticks());
		settle_outputs();

		// Longest counts, then shorter ones while the frame is still going.
		write_tick_count(spimc_pkg::REG_CLOCK_HIGH, 8'd255);
		write_tick_count(spimc_pkg::REG_CLOCK_LOW, 8'd255);
		queue_transfer(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
		               8'($urandom_range(0, 255)), 258);
		settle_outputs();
		write_tick_count(spimc_pkg::REG_CLOCK_LOW, 8'd1);
		write_tick_count(spimc_pkg::REG_CLOCK_HIGH, 8'd1);
		queue_plain(frame_ticks() + 4);
		settle_outputs();

		while (random_ticks < RANDOM_TICKS) begin
			if (transfers_left == 0) begin
				settle_outputs();
				write_tick_count(spimc_pkg::REG_CLOCK_HIGH, pick_tick_count());
				write_tick_count(spimc_pkg::REG_CLOCK_LOW, pick_tick_count());
				transfers_left = $urandom_range(1, 3);
			end
			gaps = $urandom_range(0, 3);
			repeat (gaps)
				queue_tick(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			len = frame_ticks();
			if ($urandom_range(0, 5) == 0)
				len = $urandom_range(1, len - 1);
			queue_transfer(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			               8'($urandom_range(0, 255)), len);
			random_ticks += len + gaps;
			transfers_left--;
		end

		settle_outputs();
		repeat (END_TAIL) @(posedge clk);
		if (expected_pins.size() != 0)
			report_mismatch("results never delivered", expected_pins.size(), '0);
		$display("Checked %0d ticks, %0d complete frames, %0d tick-count writes.",
		         results_checked, transfers_done, settings_written);
		$display("Included zero and 255 counts, mid-frame count changes and a long stall.");
		if (mismatch_count == 0) begin
			$display("spi_master_crc8_transaction_test OK");
		end else begin
			$display("spi_master_crc8_transaction_test NOT OK");
		end
		$finish;
	end

endmodule
